>>> hw/rtl/ksa_pkg.sv
// Shared item types and operation and status codes for the shared-array stack block.
package ksa_pkg;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	localparam int VALUE_W = 32;
	localparam int SEL_W   = 2;

	typedef struct packed {
		logic                       cmd;
		logic [SEL_W-1:0]           stack_sel;
		logic signed [VALUE_W-1:0]  push_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  pop_value;
		logic [1:0]                 status;
	} rsp_t;

endpackage

>>> hw/rtl/k_stacks_shared_array.sv
// Push completes in the top-read state and pop in the pop state, results registered;
// an underflowing pop completes in the top-read state. One item at a time: a new item
// is taken only in idle, after the dependent top and slot reads through synchronous memories.
// Reset is asynchronous: stack tops clear through per-stack valid bits and the free list
// comes up through a fill count below which slots have been used, so there is no clearing pass.
// Slot values are undefined until pushed.
module k_stacks_shared_array import ksa_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int STACKS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DEPTH + 1);
	localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam logic [PW-1:0] NULL_PTR = PW'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TOP  = 3'b010,
		ST_POP  = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic                       cmd_s1;
	logic [SEL_W-1:0]           sel_s1;
	logic signed [VALUE_W-1:0]  val_s1;
	logic [PW-1:0]              top_s2;
	logic [PW-1:0]              free_head_q, free_head_d;
	logic [PW-1:0]              fresh_q, fresh_d;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q, rsp_d;

	logic                       sel_ok, out_free, finish;
	logic [PW-1:0]              top_ptr;
	logic [PW-1:0]              slot_rlink;
	logic signed [VALUE_W-1:0]  slot_rdata;
	logic                       slot_we;
	logic [AW-1:0]              slot_waddr, slot_raddr;
	logic [PW-1:0]              slot_wlink;
	logic signed [VALUE_W-1:0]  slot_wdata;
	logic                       top_we;
	logic [SW-1:0]              top_raddr, top_waddr;
	logic [PW-1:0]              top_wptr;

	ksa_slot_mem #(.DEPTH(DEPTH)) u_slot_mem (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wlink (slot_wlink),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rlink (slot_rlink),
		.rdata (slot_rdata)
	);

	ksa_top_mem #(.DEPTH(DEPTH), .STACKS(STACKS)) u_top_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (top_we),
		.waddr  (top_waddr),
		.wptr   (top_wptr),
		.raddr  (top_raddr),
		.rptr   (top_ptr)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign sel_ok    = (32'(sel_s1) < STACKS);
	assign top_raddr = (state_q == ST_IDLE) ? SW'(req.stack_sel) : SW'(sel_s1);
	assign top_waddr = SW'(sel_s1);

	always_comb begin
		state_d     = state_q;
		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		finish      = 1'b0;
		rsp_d       = '{pop_value: '0, status: STATUS_OK};
		slot_we     = 1'b0;
		slot_waddr  = AW'(free_head_q);
		slot_wlink  = top_ptr;
		slot_wdata  = val_s1;
		slot_raddr  = AW'(free_head_q);
		top_we      = 1'b0;
		top_wptr    = free_head_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_TOP;
				end
			end
			ST_TOP: begin
				if (cmd_s1 == CMD_PUSH) begin
					if (!sel_ok || free_head_q >= NULL_PTR) begin
						rsp_d.status = STATUS_OVERFLOW;
					end else begin
						slot_we  = out_free;
						top_we   = out_free;
						top_wptr = free_head_q;
						// Slots at or above the fill count were never used, so the next free slot is the next index.
						if (free_head_q < fresh_q) begin
							free_head_d = slot_rlink;
						end else begin
							free_head_d = PW'(free_head_q + PW'(1));
							fresh_d     = PW'(fresh_q + PW'(1));
						end
						if (!out_free) begin
							free_head_d = free_head_q;
							fresh_d     = fresh_q;
						end
					end
					if (out_free) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					slot_raddr = AW'(top_ptr);
					if (!sel_ok || top_ptr >= NULL_PTR) begin
						rsp_d.status = STATUS_UNDERFLOW;
						if (out_free) begin
							finish  = 1'b1;
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				slot_raddr      = AW'(top_s2);
				slot_waddr      = AW'(top_s2);
				slot_wlink      = free_head_q;
				slot_wdata      = slot_rdata;
				top_wptr        = slot_rlink;
				rsp_d.pop_value = slot_rdata;
				if (out_free) begin
					slot_we     = 1'b1;
					top_we      = 1'b1;
					free_head_d = top_s2;
					finish      = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= '0;
			fresh_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			fresh_q     <= fresh_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			cmd_s1 <= req.cmd;
			sel_s1 <= req.stack_sel;
			val_s1 <= req.push_value;
		end
		if (state_q == ST_TOP) begin
			top_s2 <= top_ptr;
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NULL_PTR)
		else $error("fill count ran past the slot count");

	a_free_below_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= fresh_q)
		else $error("free list head points at a slot beyond the fill count");

	a_pop_real_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |-> top_s2 < NULL_PTR)
		else $error("pop stage entered with an empty stack top");

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q != ST_IDLE))
		else $error("item result produced while no item was in progress");

endmodule

>>> hw/rtl/ksa_slot_mem.sv
// Slot memory: one entry per slot holding the link to the slot below and the stored value.
module ksa_slot_mem import ksa_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [$clog2(DEPTH+1)-1:0]    wlink,
	input  logic signed [VALUE_W-1:0]     wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [$clog2(DEPTH+1)-1:0]    rlink,
	output logic signed [VALUE_W-1:0]     rdata
);

	localparam int PW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [PW-1:0]              link;
		logic signed [VALUE_W-1:0]  data;
	} entry_t;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= '{link: wlink, data: wdata};
		end
		rd_q <= mem[raddr];
	end

	assign rlink = rd_q.link;
	assign rdata = rd_q.data;

endmodule

>>> hw/rtl/ksa_top_mem.sv
// Stack-top memory: one top pointer per stack, with valid bits so every stack resets empty.
module ksa_top_mem import ksa_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int STACKS = 4
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        we,
	input  logic [((STACKS > 1) ? $clog2(STACKS) : 1)-1:0] waddr,
	input  logic [$clog2(DEPTH+1)-1:0]                  wptr,
	input  logic [((STACKS > 1) ? $clog2(STACKS) : 1)-1:0] raddr,
	output logic [$clog2(DEPTH+1)-1:0]                  rptr
);

	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] NULL_PTR = PW'(DEPTH);

	logic [PW-1:0]     mem [STACKS];
	logic [STACKS-1:0] vld_q;
	logic [PW-1:0]     rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wptr;
		end
		rdata_q <= mem[raddr];
	end

	// An entry that was never written reads as an empty stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rptr = rvld_q ? rdata_q : NULL_PTR;

endmodule
